// ===== rtl/core/sbpd_pkg.sv =====
// Shared types and constants for the single-button PWM dimmer.
// No dependencies; imported by every module of the block.
package sbpd_pkg;

    localparam logic [7:0]  LEVEL_MAX     = 8'd254;
    localparam logic [7:0]  LEVEL_MIN     = 8'd1;
    localparam logic [4:0]  DUTY_BITS_MAX = 5'd20;
    localparam logic [15:0] HOLD_SAT      = 16'hFFFF;

    localparam int DUTY_W = 20;
    localparam int PROD_W = 28;
    localparam int DIV_SHIFT = 34;
    // ceil(2^34 / 127): exact floor division by 127 for 27-bit dividends
    localparam logic [27:0] DIV_MULT = 28'd135274561;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_ACTIVE_HIGH = 3'd0;
    localparam logic [2:0] REG_LONG_TICKS  = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd2;
    localparam logic [2:0] REG_DEF_LEVEL   = 3'd3;
    localparam logic [2:0] REG_DUTY_BITS   = 3'd4;

    localparam logic        RST_ACTIVE_HIGH = 1'b0;
    localparam logic [15:0] RST_LONG_TICKS  = 16'd20;
    localparam logic [7:0]  RST_RAMP_STEP   = 8'd5;
    localparam logic [7:0]  RST_DEF_LEVEL   = 8'd128;
    localparam logic [4:0]  RST_DUTY_BITS   = 5'd13;
    localparam logic [7:0]  RST_BRIGHT      = 8'd128;

    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_ON    = 2'd1,
        CMD_OFF   = 2'd2,
        CMD_LEVEL = 2'd3
    } cmd_t;

    typedef struct packed {
        logic        button_active_high;
        logic [15:0] long_press_ticks;
        logic [7:0]  ramp_step;
        logic [7:0]  start_level;
        logic [4:0]  duty_bits;
    } cfg_t;

    // Per-request outcome of the state update
    typedef struct packed {
        logic       wr;
        logic [7:0] wlvl;
        logic       fade;
        logic       lamp_on;
        logic [7:0] level;
        logic       notify;
    } res_t;

endpackage

// ===== rtl/core/sbpd_regs.sv =====
// APB-style configuration register file for the dimmer.
// Depends on sbpd_pkg for register indexes and reset values.
module sbpd_regs
    import sbpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ACTIVE_HIGH: cfg_next.button_active_high = pwdata[0];
                REG_LONG_TICKS:  cfg_next.long_press_ticks   = pwdata[15:0];
                REG_RAMP_STEP:   cfg_next.ramp_step          = pwdata[7:0];
                REG_DEF_LEVEL:   cfg_next.start_level        = pwdata[7:0];
                REG_DUTY_BITS:   cfg_next.duty_bits          = pwdata[4:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ACTIVE_HIGH: prdata = {31'd0, cfg_reg.button_active_high};
            REG_LONG_TICKS:  prdata = {16'd0, cfg_reg.long_press_ticks};
            REG_RAMP_STEP:   prdata = {24'd0, cfg_reg.ramp_step};
            REG_DEF_LEVEL:   prdata = {24'd0, cfg_reg.start_level};
            REG_DUTY_BITS:   prdata = {27'd0, cfg_reg.duty_bits};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_active_high <= RST_ACTIVE_HIGH;
            cfg_reg.long_press_ticks   <= RST_LONG_TICKS;
            cfg_reg.ramp_step          <= RST_RAMP_STEP;
            cfg_reg.start_level        <= RST_DEF_LEVEL;
            cfg_reg.duty_bits          <= RST_DUTY_BITS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/sbpd_state.sv =====
// Lamp state update: button tracking, long-press ramp, remote commands.
// Depends on sbpd_pkg; registers one res_t per request.
module sbpd_state
    import sbpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  cmd_t       cmd,
    input  logic       button_sample,
    input  logic [7:0] new_level,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       res
);

    logic        on_reg, on_next;
    logic [7:0]  bright_reg, bright_next;
    logic        pressed_reg, pressed_next;
    logic        long_reg, long_next;
    logic        up_reg, up_next;
    logic [15:0] hold_reg, hold_next;
    logic        vld_reg, vld_next;
    res_t        res_reg, res_next;

    logic              take;
    logic              cur;
    logic [15:0]       hold_inc;
    logic [7:0]        bl_on;
    logic [7:0]        base;
    logic signed [9:0] nl;
    logic [7:0]        nl_c;
    logic              up_t;
    logic [7:0]        set_lvl;

    assign in_ready  = !vld_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign res       = res_reg;

    always_comb
    begin
        cur      = (button_sample == cfg.button_active_high);
        hold_inc = (hold_reg != HOLD_SAT) ? hold_reg + 16'd1 : hold_reg;
        bl_on    = (bright_reg == 8'd0) ? cfg.start_level : bright_reg;
        base     = (!long_reg && !on_reg) ? bl_on : bright_reg;
        nl       = up_reg ? $signed({2'b00, base}) + $signed({2'b00, cfg.ramp_step})
                          : $signed({2'b00, base}) - $signed({2'b00, cfg.ramp_step});
        up_t     = up_reg;
        if (nl >= $signed({2'b00, LEVEL_MAX}))
        begin
            nl_c = LEVEL_MAX;
            up_t = 1'b0;
        end
        else if (nl <= $signed({2'b00, LEVEL_MIN}))
        begin
            nl_c = LEVEL_MIN;
            up_t = 1'b1;
        end
        else
        begin
            nl_c = nl[7:0];
        end
        set_lvl = (new_level > LEVEL_MAX) ? LEVEL_MAX : new_level;
    end

    always_comb
    begin
        on_next      = on_reg;
        bright_next  = bright_reg;
        pressed_next = pressed_reg;
        long_next    = long_reg;
        up_next      = up_reg;
        hold_next    = hold_reg;
        res_next     = '0;

        unique case (cmd)
            CMD_POLL:
            begin
                if (cur && !pressed_reg)
                begin
                    pressed_next = 1'b1;
                    long_next    = 1'b0;
                    hold_next    = 16'd0;
                end
                else if (cur && pressed_reg)
                begin
                    hold_next = hold_inc;
                    if (hold_inc >= cfg.long_press_ticks)
                    begin
                        long_next = 1'b1;
                        // lamp is switched on only when the press first turns long
                        if (!long_reg)
                        begin
                            on_next = 1'b1;
                        end
                        bright_next     = nl_c;
                        up_next         = up_t;
                        res_next.wr     = on_next;
                        res_next.wlvl   = nl_c;
                        res_next.notify = 1'b1;
                    end
                end
                else if (!cur && pressed_reg)
                begin
                    pressed_next = 1'b0;
                    if (long_reg)
                    begin
                        up_next = !up_reg;
                    end
                    else if (on_reg)
                    begin
                        on_next         = 1'b0;
                        res_next.wr     = 1'b1;
                        res_next.fade   = 1'b1;
                        res_next.notify = 1'b1;
                    end
                    else
                    begin
                        on_next         = 1'b1;
                        bright_next     = bl_on;
                        res_next.wr     = 1'b1;
                        res_next.wlvl   = bl_on;
                        res_next.fade   = 1'b1;
                        res_next.notify = 1'b1;
                    end
                end
            end
            CMD_ON:
            begin
                on_next         = 1'b1;
                bright_next     = bl_on;
                res_next.wr     = 1'b1;
                res_next.wlvl   = bl_on;
                res_next.fade   = 1'b1;
                res_next.notify = 1'b1;
            end
            CMD_OFF:
            begin
                on_next         = 1'b0;
                res_next.wr     = 1'b1;
                res_next.fade   = 1'b1;
                res_next.notify = 1'b1;
            end
            CMD_LEVEL:
            begin
                bright_next     = set_lvl;
                res_next.notify = 1'b1;
                if (on_reg)
                begin
                    res_next.wr = 1'b1;
                    if (set_lvl == 8'd0)
                    begin
                        on_next       = 1'b0;
                        res_next.fade = 1'b1;
                    end
                    else
                    begin
                        res_next.wlvl = set_lvl;
                    end
                end
            end
        endcase

        res_next.lamp_on = on_next;
        res_next.level   = bright_next;
        vld_next         = take || (vld_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg      <= 1'b0;
            bright_reg  <= RST_BRIGHT;
            pressed_reg <= 1'b0;
            long_reg    <= 1'b0;
            up_reg      <= 1'b1;
            hold_reg    <= 16'd0;
            vld_reg     <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (take)
            begin
                on_reg      <= on_next;
                bright_reg  <= bright_next;
                pressed_reg <= pressed_next;
                long_reg    <= long_next;
                up_reg      <= up_next;
                hold_reg    <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/sbpd_duty.sv =====
// Level-to-duty scaling pipeline and result register.
// Depends on sbpd_pkg; duty = level * (2^bits - 1) / 254 via reciprocal multiply.
module sbpd_duty
    import sbpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        duty_bits,
    input  logic              in_valid,
    output logic              in_ready,
    input  res_t              in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DUTY_W-1:0] duty,
    output res_t              out_res
);

    logic              v2_reg, v3_reg, v4_reg;
    logic              rdy2, rdy3, rdy4;
    logic              ld2, ld3, ld4;
    res_t              res2_reg, res3_reg, res4_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DUTY_W-1:0] q_reg, q_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    logic [4:0]        bits;
    logic [DUTY_W-1:0] full;
    logic [7:0]        lvl_c;
    logic [54:0]       scaled;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;
    assign ld2      = in_valid && rdy2;
    assign ld3      = v2_reg && rdy3;
    assign ld4      = v3_reg && rdy4;

    assign out_valid = v4_reg;
    assign duty      = duty_reg;
    assign out_res   = res4_reg;

    always_comb
    begin
        bits      = (duty_bits > DUTY_BITS_MAX) ? DUTY_BITS_MAX : duty_bits;
        full      = DUTY_W'((21'd1 << bits) - 21'd1);
        lvl_c     = (in_res.wlvl > LEVEL_MAX) ? LEVEL_MAX : in_res.wlvl;
        prod_next = PROD_W'(lvl_c) * PROD_W'(full);
        // floor(x / 254) = floor(floor(x / 2) / 127)
        scaled    = 55'(prod_reg[PROD_W-1:1]) * 55'(DIV_MULT);
        q_next    = scaled[DIV_SHIFT+DUTY_W-1:DIV_SHIFT];
        duty_next = res3_reg.wr ? q_reg : duty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            duty_reg <= '0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= in_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld4)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            res2_reg <= in_res;
            prod_reg <= prod_next;
        end
        if (ld3)
        begin
            res3_reg <= res2_reg;
            q_reg    <= q_next;
        end
        if (ld4)
        begin
            res4_reg <= res3_reg;
        end
    end

endmodule

// ===== rtl/core/single_button_pwm_dimmer.sv =====
// Top level of the single-button PWM dimmer: input register, state update,
// duty pipeline and APB register file. Depends on sbpd_pkg, sbpd_regs,
// sbpd_state and sbpd_duty.
//
//   port group   dir   payload
//   s_*          in    tuser: cmd[1:0]; tdata: button_sample, new_level
//   m_*          out   tdata: duty, fade, lamp_on, level, notify
//   p*           in    APB register writes and reads, 5 registers
//
// One request per cycle sustained while m_tready holds high; each result is
// registered in turn by the state, product, quotient and output registers
// behind the input register.
// The product and reciprocal multiply of the duty scaling set the depth.
// Reset clears lamp state to off, level 128, ramp upward; registers to defaults.
// Each stage advances when the next one is empty or moving, so a stalled
// result still leaves room for new requests until the pipeline is full.
module single_button_pwm_dimmer
    import sbpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [0] button_sample, [8:1] new_level
    input  logic [1:0]        s_tuser,   // [1:0] cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [19:0] duty, [20] fade, [21] lamp_on,
                                         // [29:22] level, [30] notify
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t              cfg;
    logic              v0_reg;
    cmd_t              cmd_reg;
    logic              sample_reg;
    logic [7:0]        level_in_reg;
    logic              st_ready;
    logic              st_valid;
    res_t              st_res;
    logic              du_ready;
    logic [DUTY_W-1:0] duty;
    res_t              out_res;
    logic              take;

    assign pready   = 1'b1;
    assign s_tready = !v0_reg || st_ready;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg      <= cmd_t'(s_tuser);
            sample_reg   <= s_tdata[0];
            level_in_reg <= s_tdata[8:1];
        end
    end

    sbpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sbpd_state u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (v0_reg),
        .in_ready      (st_ready),
        .cmd           (cmd_reg),
        .button_sample (sample_reg),
        .new_level     (level_in_reg),
        .out_valid     (st_valid),
        .out_ready     (du_ready),
        .res           (st_res)
    );

    sbpd_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .duty_bits (cfg.duty_bits),
        .in_valid  (st_valid),
        .in_ready  (du_ready),
        .in_res    (st_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .duty      (duty),
        .out_res   (out_res)
    );

    assign m_tdata = {1'b0, out_res.notify, out_res.level, out_res.lamp_on,
                      out_res.fade, duty};

endmodule
